@@ hw/rtl/spnm_pkg.sv @@
package spnm_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        CFG_SCALE  = 3'd0,
        CFG_OCTAVE = 3'd1,
        CFG_KEY    = 3'd2,
        CFG_BASE   = 3'd3,
        CFG_GUITAR = 3'd4,
        CFG_CHORD  = 3'd5,
        CFG_FRET   = 3'd6
    } t_cfg_idx;

    localparam int unsigned NUM_SCALES = 19;
    localparam logic [4:0] SCALE_COUNT = 5'd19;
    localparam logic signed [3:0] OCT_MAX = 4'sd4;
    localparam logic signed [3:0] OCT_MIN = -4'sd4;
    localparam logic [3:0] KEY_WRAP = 4'd12;
    localparam logic [6:0] NOTE_MAX = 7'd127;
    localparam logic [6:0] BASE_RESET = 7'd48;

    // Number of intervals in each scale, chromatic first.
    localparam logic [3:0] SCALE_LEN [NUM_SCALES] = '{
        4'd12, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd6, 4'd6,
        4'd7, 4'd8, 4'd8, 4'd5, 4'd5, 4'd5, 4'd6, 4'd5, 4'd7
    };

    // Interval tables in semitones; entries past the scale length are unused.
    localparam logic [3:0] SCALE_IV [NUM_SCALES][12] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd4, 4'd5, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd6, 4'd8, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd3, 4'd4, 4'd6, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd5, 4'd7, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd3, 4'd6, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
    };

    // Open string notes, top row first.
    localparam logic [6:0] OPEN_NOTE [4] = '{7'd43, 7'd38, 7'd33, 7'd28};

    // White keys by pitch class.
    localparam logic NATURAL_PC [12] = '{
        1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1
    };

    // Configuration as seen by the pipeline.
    typedef struct packed {
        logic [4:0]        scale_sel;
        logic signed [3:0] oct_shift;
        logic [3:0]        key;
        logic [6:0]        base;
        logic              guitar;
        logic              chord;
        logic [4:0]        fret_ofs;
    } t_cfg;

    // Decoded pad position.
    typedef struct packed {
        logic       hit;
        logic       in_strip;
        logic [1:0] row_idx;
        logic [4:0] scale;
        logic [3:0] len;
        logic [4:0] deg;
        logic [4:0] cdeg;
        logic [4:0] fret;
    } t_s1;

    // Degrees split into octave and scale index, plus fret results.
    typedef struct packed {
        logic            hit;
        logic            in_strip;
        logic [4:0]      scale;
        logic [2:0]      oct_m;
        logic [3:0]      idx_m;
        logic [2:0][2:0] oct_c;
        logic [2:0][3:0] idx_c;
        logic [6:0]      gnote;
        logic            is_root;
        logic            fret_mark;
        logic            oct_mark;
    } t_s2;

    // Finished notes, before the pitch class flag.
    typedef struct packed {
        logic       hit;
        logic [6:0] note;
        logic       chord_valid;
        logic [6:0] root;
        logic [6:0] third;
        logic [6:0] fifth;
        logic       is_root;
        logic       is_chord_region;
        logic       fret_mark;
        logic       oct_mark;
    } t_s3;

    // Result beat fields.
    typedef struct packed {
        logic       is_octave_marker;
        logic       is_fret_marker;
        logic       is_chord_region;
        logic       is_natural;
        logic       is_root;
        logic [6:0] chord_fifth_note;
        logic [6:0] chord_third_note;
        logic [6:0] chord_root_note;
        logic       chord_valid;
        logic [6:0] note;
    } t_out;

    // Splits a degree into octave and scale index by a scale length of five or more.
    function automatic logic [6:0] deg_divmod(input logic [4:0] deg, input logic [3:0] len);
        logic [2:0] oct;
        logic [6:0] prod;
        logic [6:0] rem;
        oct = 3'd0;
        for (int k = 1; k <= 6; k++) begin
            prod = 7'(k) * {3'b000, len};
            if ({2'b00, deg} >= prod) begin
                oct = oct + 3'd1;
            end
        end
        rem = {2'b00, deg} - 7'(7'(oct) * {3'b000, len});
        return {oct, rem[3:0]};
    endfunction

    // Clamps a signed note sum to the MIDI range.
    function automatic logic [6:0] clamp_note(input logic signed [9:0] n);
        logic [6:0] r;
        if (n < 10'sd0) begin
            r = 7'd0;
        end else if (n > 10'sd127) begin
            r = NOTE_MAX;
        end else begin
            r = n[6:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/spnm_decode.sv @@
module spnm_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spnm_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_present,
    input  logic [2:0]      i_row,
    input  logic [2:0]      i_col,
    output logic            o_valid,
    input  logic            i_ready,
    output spnm_pkg::t_s1   o_data
);
    import spnm_pkg::*;

    logic       r_valid;
    t_s1        r_data;
    t_s1        n_data;
    logic [1:0] mrow;
    logic [2:0] c0;
    logic [4:0] cdeg_strip;
    logic [4:0] cdeg_mel;
    logic [4:0] ndeg;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Position checks and the three degree maps.
    always_comb begin
        mrow       = 2'(3'd4 - i_row);
        c0         = i_col - 3'd1;
        cdeg_strip = {2'b00, mrow, 1'b0} + {2'b00, c0};
        cdeg_mel   = {1'b0, mrow, 2'b00} + {2'b00, 3'(i_col - 3'd3)};
        ndeg       = {1'b0, mrow, 2'b00} + {2'b00, mrow, 1'b0} + {2'b00, c0};

        n_data.hit      = i_present && (i_row >= 3'd1) && (i_row <= 3'd4)
                          && (i_col >= 3'd1) && (i_col <= 3'd6);
        n_data.in_strip = (i_col <= 3'd2);
        n_data.row_idx  = 2'(i_row - 3'd1);
        n_data.scale    = (i_cfg.scale_sel < SCALE_COUNT) ? i_cfg.scale_sel : 5'd0;
        n_data.len      = SCALE_LEN[n_data.scale];
        n_data.cdeg     = n_data.in_strip ? cdeg_strip : cdeg_mel;
        n_data.deg      = i_cfg.chord ? n_data.cdeg : ndeg;
        n_data.fret     = i_cfg.fret_ofs + {2'b00, c0};
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

@@ hw/rtl/spnm_divmod.sv @@
module spnm_divmod (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  spnm_pkg::t_s1  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output spnm_pkg::t_s2  o_data
);
    import spnm_pkg::*;

    logic       r_valid;
    t_s2        r_data;
    t_s2        n_data;
    logic [6:0] dm_main;
    logic [6:0] dm_chord [3];
    logic [4:0] fret_mod;
    logic [7:0] gsum;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Octave and index of the pad degree and of the three triad degrees.
    always_comb begin
        dm_main     = deg_divmod(i_data.deg, i_data.len);
        dm_chord[0] = deg_divmod(i_data.cdeg, i_data.len);
        dm_chord[1] = deg_divmod(i_data.cdeg + 5'd2, i_data.len);
        dm_chord[2] = deg_divmod(i_data.cdeg + 5'd4, i_data.len);

        n_data.hit      = i_data.hit;
        n_data.in_strip = i_data.in_strip;
        n_data.scale    = i_data.scale;
        n_data.oct_m    = dm_main[6:4];
        n_data.idx_m    = dm_main[3:0];
        for (int i = 0; i < 3; i++) begin
            n_data.oct_c[i] = dm_chord[i][6:4];
            n_data.idx_c[i] = dm_chord[i][3:0];
        end
        n_data.is_root = (dm_main[3:0] == 4'd0);

        // Fret note and inlay markers.
        if (i_data.fret >= 5'd24) begin
            fret_mod = i_data.fret - 5'd24;
        end else if (i_data.fret >= 5'd12) begin
            fret_mod = i_data.fret - 5'd12;
        end else begin
            fret_mod = i_data.fret;
        end
        n_data.oct_mark  = (i_data.fret != 5'd0) && (fret_mod == 5'd0);
        n_data.fret_mark = n_data.oct_mark || (fret_mod inside {5'd3, 5'd5, 5'd7, 5'd9});

        gsum = {1'b0, OPEN_NOTE[i_data.row_idx]} + {3'b000, i_data.fret};
        n_data.gnote = (gsum > {1'b0, NOTE_MAX}) ? NOTE_MAX : gsum[6:0];
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

@@ hw/rtl/spnm_note.sv @@
module spnm_note (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spnm_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  spnm_pkg::t_s2  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output spnm_pkg::t_s3  o_data
);
    import spnm_pkg::*;

    logic              r_valid;
    t_s3               r_data;
    t_s3               n_data;
    logic signed [9:0] ofs;
    logic signed [9:0] sum_m;
    logic signed [9:0] sum_c [3];
    logic [6:0]        note_c [3];
    logic              chord_on;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Scale note sums: base, key and octave shift, plus octave and interval.
    always_comb begin
        ofs   = signed'({3'b000, i_cfg.base}) + signed'({6'b000000, i_cfg.key})
                + 10'(10'(i_cfg.oct_shift) * 10'sd12);
        sum_m = ofs + signed'(10'(10'(i_data.oct_m) * 10'd12))
                + signed'({6'b000000, SCALE_IV[i_data.scale][i_data.idx_m]});
        for (int i = 0; i < 3; i++) begin
            sum_c[i] = ofs + signed'(10'(10'(i_data.oct_c[i]) * 10'd12))
                       + signed'({6'b000000, SCALE_IV[i_data.scale][i_data.idx_c[i]]})
                       - 10'sd12;
            note_c[i] = clamp_note(sum_c[i]);
        end
    end

    // Mode selection and zeroing of absent pads and inactive chord fields.
    always_comb begin
        chord_on               = i_data.hit && i_cfg.chord && i_data.in_strip;
        n_data.hit             = i_data.hit;
        n_data.note            = !i_data.hit ? 7'd0
                                 : (i_cfg.guitar ? i_data.gnote : clamp_note(sum_m));
        n_data.chord_valid     = chord_on;
        n_data.root            = chord_on ? note_c[0] : 7'd0;
        n_data.third           = chord_on ? note_c[1] : 7'd0;
        n_data.fifth           = chord_on ? note_c[2] : 7'd0;
        n_data.is_root         = i_data.hit && i_data.is_root;
        n_data.is_chord_region = chord_on;
        n_data.fret_mark       = i_data.hit && i_data.fret_mark;
        n_data.oct_mark        = i_data.hit && i_data.oct_mark;
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

@@ hw/rtl/spnm_pitch.sv @@
module spnm_pitch (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  spnm_pkg::t_s3  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output spnm_pkg::t_out o_data
);
    import spnm_pkg::*;

    logic        r_valid;
    t_out        r_data;
    t_out        n_data;
    logic [13:0] prod;
    logic [3:0]  quot;
    logic [6:0]  pc;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Pitch class by reciprocal: n * 43 / 512 is n / 12 rounded down for n up to 127.
    always_comb begin
        prod = {7'd0, i_data.note} * 14'd43;
        quot = prod[12:9];
        pc   = i_data.note - 7'(7'(quot) * 7'd12);

        n_data.note             = i_data.note;
        n_data.chord_valid      = i_data.chord_valid;
        n_data.chord_root_note  = i_data.root;
        n_data.chord_third_note = i_data.third;
        n_data.chord_fifth_note = i_data.fifth;
        n_data.is_root          = i_data.is_root;
        n_data.is_natural       = i_data.hit && NATURAL_PC[pc[3:0]];
        n_data.is_chord_region  = i_data.is_chord_region;
        n_data.is_fret_marker   = i_data.fret_mark;
        n_data.is_octave_marker = i_data.oct_mark;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

@@ hw/rtl/scale_pad_note_mapper.sv @@
// An accepted input beat passes the decode, divmod, note and pitch stage registers.
// Throughput: one beat per cycle; each of the four stages has its own valid bit and
// holds its beat while the stage after it is full and stalled.
// Reset (synchronous, active low) empties the pipeline and loads every
// configuration register with its reset value; no clearing pass is needed.
module scale_pad_note_mapper #(
    parameter int MAX_FRET = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [6:0]  i_cfg_data,
    // Input stream: [0] pad_present, [3:1] pad_row, [6:4] pad_col, [7] zero.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    // Output stream: [6:0] note, [7] chord_valid, [14:8] chord_root_note,
    // [21:15] chord_third_note, [28:22] chord_fifth_note, [29] is_root,
    // [30] is_natural, [31] is_chord_region, [32] is_fret_marker,
    // [33] is_octave_marker, [39:34] zero.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata
);
    import spnm_pkg::*;

    localparam logic [4:0] FRET_LIM = 5'(MAX_FRET - 5);

    t_cfg              r_cfg;
    logic signed [3:0] wr_oct;
    logic [3:0]        wr_key;
    logic [4:0]        wr_fret;

    logic v1;
    logic v2;
    logic v3;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    t_s1  d1;
    t_s2  d2;
    t_s3  d3;
    t_out d4;

    // Saturation and wrapping of written values.
    always_comb begin
        wr_oct = signed'(i_cfg_data[3:0]);
        if (wr_oct > OCT_MAX) begin
            wr_oct = OCT_MAX;
        end else if (wr_oct < OCT_MIN) begin
            wr_oct = OCT_MIN;
        end
        wr_key  = (i_cfg_data[3:0] >= KEY_WRAP) ? (i_cfg_data[3:0] - KEY_WRAP)
                                                : i_cfg_data[3:0];
        wr_fret = (i_cfg_data[4:0] > FRET_LIM) ? FRET_LIM : i_cfg_data[4:0];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_sel <= 5'd0;
            r_cfg.oct_shift <= 4'sd0;
            r_cfg.key       <= 4'd0;
            r_cfg.base      <= BASE_RESET;
            r_cfg.guitar    <= 1'b0;
            r_cfg.chord     <= 1'b0;
            r_cfg.fret_ofs  <= 5'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SCALE:  r_cfg.scale_sel <= i_cfg_data[4:0];
                CFG_OCTAVE: r_cfg.oct_shift <= wr_oct;
                CFG_KEY:    r_cfg.key       <= wr_key;
                CFG_BASE:   r_cfg.base      <= i_cfg_data;
                CFG_GUITAR: r_cfg.guitar    <= i_cfg_data[0];
                CFG_CHORD:  r_cfg.chord     <= i_cfg_data[0];
                CFG_FRET:   r_cfg.fret_ofs  <= wr_fret;
                default: begin
                end
            endcase
        end
    end

    // Pipeline stages.
    spnm_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_present (i_s_tdata[0]),
        .i_row     (i_s_tdata[3:1]),
        .i_col     (i_s_tdata[6:4]),
        .o_valid   (v1),
        .i_ready   (rdy2),
        .o_data    (d1)
    );

    spnm_divmod u_divmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .o_ready (rdy2),
        .i_data  (d1),
        .o_valid (v2),
        .i_ready (rdy3),
        .o_data  (d2)
    );

    spnm_note u_note (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (v2),
        .o_ready (rdy3),
        .i_data  (d2),
        .o_valid (v3),
        .i_ready (rdy4),
        .o_data  (d3)
    );

    spnm_pitch u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v3),
        .o_ready (rdy4),
        .i_data  (d3),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (d4)
    );

    assign o_m_tdata = {6'b000000, d4};

`ifndef SYNTHESIS
    // The input side stalls only behind a result beat that is held on the output.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without a held result beat");

    // A valid triad is always reported inside the chord strip.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[7]) |-> o_m_tdata[31])
        else $error("chord_valid outside the chord region");

    // Chord notes are zero whenever the triad is not valid.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[7]) |-> (o_m_tdata[28:8] == 21'd0))
        else $error("chord notes not zeroed");

    // An octave inlay is always a fret marker too.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[33]) |-> o_m_tdata[32])
        else $error("octave marker without fret marker");
`endif

endmodule

@@ test/scale_pad_note_mapper_tb.sv @@
`timescale 1ns / 1ps

module scale_pad_note_mapper_tb;

    import spnm_pkg::*;

    localparam int LATENCY     = 4;
    localparam int MAX_FRET    = 24;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // [0] pad_present, [3:1] pad_row, [6:4] pad_col, [7] zero.
    logic [7:0]  i_s_tdata  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [6:0] note, [7] chord_valid, [14:8] chord_root_note, [21:15] chord_third_note,
    // [28:22] chord_fifth_note, [29] is_root, [30] is_natural, [31] is_chord_region,
    // [32] is_fret_marker, [33] is_octave_marker, [39:34] zero.
    logic [39:0] o_m_tdata;

    // Shadow copy of the mapper configuration.
    logic [4:0] cur_scale    = 5'd0;
    int         cur_octave   = 0;
    int         cur_key      = 0;
    int         cur_base     = int'(BASE_RESET);
    logic       cur_guitar   = 1'b0;
    logic       cur_chord    = 1'b0;
    int         cur_fret_ofs = 0;

    t_out pending_notes[$];
    int   error_count   = 0;
    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    int   cycle_count   = 0;

    scale_pad_note_mapper #(
        .MAX_FRET(MAX_FRET)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("scale_pad_note_mapper_tb: errors");
            $finish;
        end
    end

    function automatic int clamp_midi(input int n);
        return (n < 0) ? 0 : ((n > 127) ? 127 : n);
    endfunction

    // Note of a scale degree with base, octave shift and key applied, not yet clamped.
    function automatic int degree_to_note(input int s, input int deg);
        int len;
        len = int'(SCALE_LEN[s]);
        return cur_base + (deg / len) * 12 + int'(SCALE_IV[s][deg % len])
               + cur_octave * 12 + cur_key;
    endfunction

    // Expected result beat for one pad beat under the current configuration.
    function automatic t_out map_pad(input logic [7:0] beat);
        t_out r;
        int   row, col, mrow, cdeg, ndeg, deg, fret, note, s, len, m;
        logic strip;
        r   = '0;
        row = int'(beat[3:1]);
        col = int'(beat[6:4]);
        if (!beat[0] || row < 1 || row > 4 || col < 1 || col > 6) begin
            return r;
        end
        // Custom scale slots fall back to chromatic.
        s     = (cur_scale < NUM_SCALES) ? int'(cur_scale) : 0;
        len   = int'(SCALE_LEN[s]);
        mrow  = 4 - row;
        strip = (col <= 2);
        cdeg  = strip ? (mrow * 2 + col - 1) : (mrow * 4 + col - 3);
        ndeg  = mrow * 6 + col - 1;
        deg   = cur_chord ? cdeg : ndeg;
        fret  = cur_fret_ofs + col - 1;

        // Guitar mode wins over the scale mapping for the note itself.
        if (cur_guitar) begin
            note = clamp_midi(int'(OPEN_NOTE[row - 1]) + fret);
        end else begin
            note = clamp_midi(degree_to_note(s, deg));
        end
        r.note = note[6:0];

        // Triad one octave down for the chord strip.
        if (cur_chord && strip) begin
            r.chord_valid      = 1'b1;
            r.chord_root_note  = 7'(clamp_midi(degree_to_note(s, cdeg) - 12));
            r.chord_third_note = 7'(clamp_midi(degree_to_note(s, cdeg + 2) - 12));
            r.chord_fifth_note = 7'(clamp_midi(degree_to_note(s, cdeg + 4) - 12));
        end

        r.is_root         = ((deg % len) == 0);
        r.is_natural      = NATURAL_PC[note % 12];
        r.is_chord_region = cur_chord && strip;

        // Inlay dots: single at 3, 5, 7, 9 within each octave and double at each nonzero octave.
        m = fret % 12;
        if (fret != 0 && m == 0) begin
            r.is_fret_marker   = 1'b1;
            r.is_octave_marker = 1'b1;
        end else if (m == 3 || m == 5 || m == 7 || m == 9) begin
            r.is_fret_marker = 1'b1;
        end
        return r;
    endfunction

    // Register write; the block is idle whenever this is called.
    task automatic cfg_write(input t_cfg_idx idx, input logic [6:0] data);
        int v;
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SCALE: begin
                cur_scale = data[4:0];
            end
            CFG_OCTAVE: begin
                v = int'(data[3:0]);
                if (v >= 8) begin
                    v -= 16;
                end
                if (v > int'(OCT_MAX)) begin
                    v = int'(OCT_MAX);
                end
                if (v < int'(OCT_MIN)) begin
                    v = int'(OCT_MIN);
                end
                cur_octave = v;
            end
            CFG_KEY: begin
                cur_key = int'(data[3:0]) % int'(KEY_WRAP);
            end
            CFG_BASE: begin
                cur_base = int'(data);
            end
            CFG_GUITAR: begin
                cur_guitar = data[0];
            end
            CFG_CHORD: begin
                cur_chord = data[0];
            end
            CFG_FRET: begin
                v = int'(data[4:0]);
                cur_fret_ofs = (v > MAX_FRET - 5) ? MAX_FRET - 5 : v;
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    // Sends one pad beat, with random idle cycles in front of it.
    task automatic send_pad(input logic present, input logic [2:0] row, input logic [2:0] col);
        logic [7:0] beat;
        beat = {1'b0, col, row, present};
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= beat;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        pending_notes.push_back(map_pad(beat));
        @(negedge i_clk);
    endtask

    // Holds the input side until every expected beat has come out.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_notes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    // Output side back-pressure.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Compares each result beat with the oldest expected one.
    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[33:0];
            if (pending_notes.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result beat, expected none actual %h", $time, got);
            end else begin
                want = pending_notes.pop_front();
                check_field("note", want.note, got.note);
                check_field("chord_valid", 7'(want.chord_valid), 7'(got.chord_valid));
                check_field("chord_root_note", want.chord_root_note, got.chord_root_note);
                check_field("chord_third_note", want.chord_third_note, got.chord_third_note);
                check_field("chord_fifth_note", want.chord_fifth_note, got.chord_fifth_note);
                check_field("is_root", 7'(want.is_root), 7'(got.is_root));
                check_field("is_natural", 7'(want.is_natural), 7'(got.is_natural));
                check_field("is_chord_region", 7'(want.is_chord_region),
                            7'(got.is_chord_region));
                check_field("is_fret_marker", 7'(want.is_fret_marker),
                            7'(got.is_fret_marker));
                check_field("is_octave_marker", 7'(want.is_octave_marker),
                            7'(got.is_octave_marker));
            end
        end
    end

    // Absent pads, positions off the grid and the grid corners at reset settings.
    task automatic test_position_decode();
        send_pad(1'b0, 3'd4, 3'd1);
        send_pad(1'b1, 3'd0, 3'd3);
        send_pad(1'b1, 3'd7, 3'd2);
        send_pad(1'b1, 3'd2, 3'd0);
        send_pad(1'b1, 3'd3, 3'd7);
        send_pad(1'b1, 3'd4, 3'd1);
        send_pad(1'b1, 3'd1, 3'd6);
        drain_results();
    endtask

    // Chord strip and melody sub-grid in a seven-note scale.
    task automatic test_chord_layout();
        cfg_write(CFG_CHORD, 7'd1);
        cfg_write(CFG_SCALE, 7'd1);
        send_pad(1'b1, 3'd4, 3'd1);
        send_pad(1'b1, 3'd1, 3'd2);
        send_pad(1'b1, 3'd4, 3'd3);
        send_pad(1'b1, 3'd1, 3'd6);
        drain_results();
    endtask

    // Guitar mapping with chord mode still on, fret offset saturated and markers.
    task automatic test_guitar_frets();
        cfg_write(CFG_GUITAR, 7'd1);
        cfg_write(CFG_FRET, 7'd31);
        send_pad(1'b1, 3'd1, 3'd6);
        send_pad(1'b1, 3'd4, 3'd1);
        send_pad(1'b1, 3'd2, 3'd4);
        drain_results();
        cfg_write(CFG_CHORD, 7'd0);
        cfg_write(CFG_FRET, 7'd12);
        send_pad(1'b1, 3'd3, 3'd1);
        send_pad(1'b1, 3'd3, 3'd4);
        drain_results();
        cfg_write(CFG_FRET, 7'd0);
        send_pad(1'b1, 3'd2, 3'd4);
        drain_results();
    endtask

    // Clamping at both ends of the note range and register saturation and wrap.
    task automatic test_clamp_and_wrap();
        cfg_write(CFG_GUITAR, 7'd0);
        cfg_write(CFG_BASE, 7'd127);
        cfg_write(CFG_OCTAVE, 7'd7);
        cfg_write(CFG_KEY, 7'd15);
        send_pad(1'b1, 3'd1, 3'd6);
        send_pad(1'b1, 3'd4, 3'd1);
        drain_results();
        cfg_write(CFG_BASE, 7'd0);
        cfg_write(CFG_OCTAVE, 7'd8);
        send_pad(1'b1, 3'd1, 3'd6);
        send_pad(1'b1, 3'd4, 3'd1);
        drain_results();
    endtask

    // An undefined custom scale falls back to chromatic.
    task automatic test_scale_fallback();
        cfg_write(CFG_SCALE, 7'd31);
        cfg_write(CFG_OCTAVE, 7'd0);
        cfg_write(CFG_BASE, 7'(BASE_RESET));
        cfg_write(CFG_KEY, 7'd11);
        send_pad(1'b1, 3'd2, 3'd3);
        send_pad(1'b1, 3'd3, 3'd5);
        drain_results();
    endtask

    // Writes every register, often with a random word and sometimes with a range end.
    task automatic randomize_config();
        logic [6:0] data;
        logic [6:0] hi;
        logic [6:0] lo;
        for (int i = 0; i < 7; i++) begin
            lo = 7'd0;
            case (t_cfg_idx'(i))
                CFG_SCALE:  hi = 7'd27;
                CFG_OCTAVE: begin
                    hi = 7'd4;
                    lo = 7'h0C;
                end
                CFG_KEY:    hi = 7'd11;
                CFG_BASE:   hi = 7'd127;
                CFG_FRET:   hi = 7'(MAX_FRET - 5);
                default:    hi = 7'd1;
            endcase
            data = 7'($urandom_range(0, 127));
            if ($urandom_range(3) == 0) begin
                data = $urandom_range(1) ? hi : lo;
            end
            cfg_write(t_cfg_idx'(i), data);
        end
    endtask

    // Random pads in blocks, a fresh configuration for each block.
    task automatic test_random_mapping(input int src_pct, input int sink_pct, input int n_items);
        int sent;
        sent          = 0;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        while (sent < n_items) begin
            drain_results();
            randomize_config();
            repeat (30) begin
                if ($urandom_range(99) < 85) begin
                    send_pad(1'b1, 3'($urandom_range(1, 4)), 3'($urandom_range(1, 6)));
                end else begin
                    send_pad(1'($urandom_range(1)), 3'($urandom_range(7)),
                             3'($urandom_range(7)));
                end
                sent++;
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_position_decode();
        test_chord_layout();
        test_guitar_frets();
        test_clamp_and_wrap();
        test_scale_fallback();
        test_random_mapping(26, 50, 450);
        test_random_mapping(50, 26, 450);
        test_random_mapping(0, 0, 450);

        if (pending_notes.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected beats never arrived", $time, pending_notes.size());
        end
        if (error_count == 0) begin
            $display("scale_pad_note_mapper_tb: clean");
        end else begin
            $display("scale_pad_note_mapper_tb: errors");
        end
        $finish;
    end

endmodule
